// ----- hdl/fcd_pkg.sv -----
// Shared types and constants for the foot contact decision block.
// No dependencies; all other files refer to this package by scoped names.
package fcd_pkg;

   localparam int unsigned LEGS = 4;
   localparam int unsigned FORCE_W = 16;
   localparam int unsigned PHASE_W = 16;
   localparam int unsigned TICK_W = 16;
   localparam int unsigned STIME_W = 24;
   localparam int unsigned RATIO_W = 9;
   localparam int unsigned TIMER_W = 24;
   localparam int unsigned MDELAY_W = 25;
   localparam int unsigned GAIT_W = 3;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // gait mode codes
   localparam logic [MODE_W-1:0] MODE_STAND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TOUCHDOWN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_RATIO = 2'd2;

   localparam logic signed [FORCE_W-1:0] TOUCHDOWN_RST = 16'sd640;
   localparam logic signed [FORCE_W-1:0] RELEASE_RST = 16'sd320;
   localparam logic [RATIO_W-1:0] HOLD_RATIO_RST = 9'd128;

   // per-leg status handed from a lane to the merge stage
   typedef struct packed {
      logic stance;
      logic delayed;
   } lane_status_type;

endpackage

// ----- hdl/foot_contact_decision.sv -----
// Foot contact decision, top level: input stage with hold-limit multiply,
// four leg lanes, merge stage and output register. Depends on fcd_pkg, fcd_lane, fcd_merge.
// rsp_valid rises once an accepted item has passed the input stage and output registers;
// a full output register with rsp_ready low holds the item in the input stage.
// Throughput: one item per cycle while rsp_ready keeps the output free; the input stage holds
// the 9x24 hold-limit product; filter, trigger and timers of all four legs update together.
// Reset clears filters, landed flags, timers, last gait and the pipeline; registers return
// to touchdown 640, release 320, hold ratio 128.
module foot_contact_decision (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fcd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fcd_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [fcd_pkg::FORCE_W-1:0]   req_force_leg0,
   input  logic signed [fcd_pkg::FORCE_W-1:0]   req_force_leg1,
   input  logic signed [fcd_pkg::FORCE_W-1:0]   req_force_leg2,
   input  logic signed [fcd_pkg::FORCE_W-1:0]   req_force_leg3,
   input  logic signed [fcd_pkg::PHASE_W-1:0]   req_swing_phase_leg0,
   input  logic signed [fcd_pkg::PHASE_W-1:0]   req_swing_phase_leg1,
   input  logic signed [fcd_pkg::PHASE_W-1:0]   req_swing_phase_leg2,
   input  logic signed [fcd_pkg::PHASE_W-1:0]   req_swing_phase_leg3,
   input  logic [fcd_pkg::TICK_W-1:0]           req_tick_time,
   input  logic [fcd_pkg::STIME_W-1:0]          req_stance_time,
   input  logic [fcd_pkg::MODE_W-1:0]           req_gait_mode,
   input  logic [fcd_pkg::GAIT_W-1:0]           req_gait_type,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fcd_pkg::LEGS-1:0]             rsp_stance_mask,
   output logic [fcd_pkg::LEGS-1:0]             rsp_delayed_mask,
   output logic signed [fcd_pkg::PHASE_W-1:0]   rsp_phase_out_leg0,
   output logic signed [fcd_pkg::PHASE_W-1:0]   rsp_phase_out_leg1,
   output logic signed [fcd_pkg::PHASE_W-1:0]   rsp_phase_out_leg2,
   output logic signed [fcd_pkg::PHASE_W-1:0]   rsp_phase_out_leg3
);

   localparam int unsigned PROD_W = fcd_pkg::RATIO_W + fcd_pkg::STIME_W;

   // configuration registers
   logic signed [fcd_pkg::FORCE_W-1:0] touchdown_ff;
   logic signed [fcd_pkg::FORCE_W-1:0] release_ff;
   logic [fcd_pkg::RATIO_W-1:0]        hold_ratio_ff;

   // input stage
   logic                                               s1_valid_ff;
   logic signed [fcd_pkg::LEGS-1:0][fcd_pkg::FORCE_W-1:0] s1_force_ff;
   logic signed [fcd_pkg::LEGS-1:0][fcd_pkg::PHASE_W-1:0] s1_phase_ff;
   logic [fcd_pkg::TICK_W-1:0]                         s1_tick_ff;
   logic [fcd_pkg::MDELAY_W-1:0]                       s1_hold_limit_ff;
   logic [fcd_pkg::MODE_W-1:0]                         s1_mode_ff;
   logic [fcd_pkg::GAIT_W-1:0]                         s1_gait_ff;

   logic [fcd_pkg::GAIT_W-1:0] last_gait_ff, last_gait_in;

   // output register
   logic                                   out_valid_ff;
   logic [fcd_pkg::LEGS-1:0]               out_stance_ff;
   logic [fcd_pkg::LEGS-1:0]               out_delayed_ff;
   logic signed [fcd_pkg::LEGS-1:0][fcd_pkg::PHASE_W-1:0] out_phase_ff;

   logic [PROD_W-1:0] product;
   logic advance;
   logic fire;
   logic req_take;
   logic running;
   logic gait_change;
   logic hold_enable;
   logic force_leg0;
   logic [fcd_pkg::LEGS-1:0] confirm;
   logic [fcd_pkg::LEGS-1:0] stance_mask;
   logic [fcd_pkg::LEGS-1:0] delayed_mask;
   fcd_pkg::lane_status_type [fcd_pkg::LEGS-1:0] status;
   logic signed [fcd_pkg::LEGS-1:0][fcd_pkg::PHASE_W-1:0] lane_phase;
   logic signed [fcd_pkg::LEGS-1:0][fcd_pkg::PHASE_W-1:0] phase_final;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         touchdown_ff <= fcd_pkg::TOUCHDOWN_RST;
         release_ff <= fcd_pkg::RELEASE_RST;
         hold_ratio_ff <= fcd_pkg::HOLD_RATIO_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fcd_pkg::CSR_TOUCHDOWN: touchdown_ff <= csr_data;
            fcd_pkg::CSR_RELEASE: release_ff <= csr_data;
            fcd_pkg::CSR_HOLD_RATIO: hold_ratio_ff <= csr_data[fcd_pkg::RATIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline control: the lane stage moves when the output register is free
   assign advance = !out_valid_ff || rsp_ready;
   assign fire = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take = req_valid && req_ready;

   assign product = {{fcd_pkg::STIME_W{1'b0}}, hold_ratio_ff} *
                    {{fcd_pkg::RATIO_W{1'b0}}, req_stance_time};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_force_ff[0] <= req_force_leg0;
         s1_force_ff[1] <= req_force_leg1;
         s1_force_ff[2] <= req_force_leg2;
         s1_force_ff[3] <= req_force_leg3;
         s1_phase_ff[0] <= req_swing_phase_leg0;
         s1_phase_ff[1] <= req_swing_phase_leg1;
         s1_phase_ff[2] <= req_swing_phase_leg2;
         s1_phase_ff[3] <= req_swing_phase_leg3;
         s1_tick_ff <= req_tick_time;
         s1_hold_limit_ff <= product[PROD_W-1:8];
         s1_mode_ff <= req_gait_mode;
         s1_gait_ff <= req_gait_type;
      end
   end

   assign running = (s1_mode_ff == fcd_pkg::MODE_RUN);
   assign gait_change = running && (s1_gait_ff != last_gait_ff);
   assign last_gait_in = (fire && gait_change) ? s1_gait_ff : last_gait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_gait_ff <= '0;
      end else begin
         last_gait_ff <= last_gait_in;
      end
   end

   for (genvar g = 0; g < fcd_pkg::LEGS; g++) begin : g_lane
      fcd_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .en              (fire),
         .running         (running),
         .gait_change     (gait_change),
         .hold_enable     (hold_enable),
         .force_val       (s1_force_ff[g]),
         .phase           (s1_phase_ff[g]),
         .tick            (s1_tick_ff),
         .hold_limit      (s1_hold_limit_ff),
         .touchdown_level (touchdown_ff),
         .release_level   (release_ff),
         .status          (status[g]),
         .confirm         (confirm[g]),
         .phase_out       (lane_phase[g])
      );
   end

   fcd_merge u_merge (
      .running      (running),
      .confirm      (confirm),
      .status       (status),
      .hold_enable  (hold_enable),
      .force_leg0   (force_leg0),
      .stance_mask  (stance_mask),
      .delayed_mask (delayed_mask)
   );

   always_comb begin
      phase_final = lane_phase;
      if (force_leg0) begin
         phase_final[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_stance_ff <= stance_mask;
         out_delayed_ff <= delayed_mask;
         out_phase_ff <= phase_final;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_stance_mask = out_stance_ff;
   assign rsp_delayed_mask = out_delayed_ff;
   assign rsp_phase_out_leg0 = out_phase_ff[0];
   assign rsp_phase_out_leg1 = out_phase_ff[1];
   assign rsp_phase_out_leg2 = out_phase_ff[2];
   assign rsp_phase_out_leg3 = out_phase_ff[3];

   a_delayed_in_stance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_delayed_mask & ~rsp_stance_mask) == '0))
      else $error("delayed leg not marked stance");

   a_running_has_stance: assert property (@(posedge clock) disable iff (reset)
      (fire && running) |=> (out_stance_ff != '0))
      else $error("running result without any stance leg");

   a_swing_phase_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stance_mask[0]) |->
         (!rsp_phase_out_leg0[fcd_pkg::PHASE_W-1] && (rsp_phase_out_leg0 != '0)))
      else $error("leg 0 swing with non-positive phase");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled with room in the pipeline");

   a_gait_tracks: assert property (@(posedge clock) disable iff (reset)
      (fire && running) |=> (last_gait_ff == $past(s1_gait_ff)))
      else $error("last gait not updated on running item");

endmodule

// ----- hdl/fcd_lane.sv -----
// One leg of the contact decision: force filter, Schmitt trigger, lift delay timer.
// Depends on fcd_pkg; holds the per-leg state and updates it when en is high.
module fcd_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   running,
   input  logic                                   gait_change,
   input  logic                                   hold_enable,
   input  logic signed [fcd_pkg::FORCE_W-1:0]     force_val,
   input  logic signed [fcd_pkg::PHASE_W-1:0]     phase,
   input  logic [fcd_pkg::TICK_W-1:0]             tick,
   input  logic [fcd_pkg::MDELAY_W-1:0]           hold_limit,
   input  logic signed [fcd_pkg::FORCE_W-1:0]     touchdown_level,
   input  logic signed [fcd_pkg::FORCE_W-1:0]     release_level,
   output fcd_pkg::lane_status_type               status,
   output logic                                   confirm,
   output logic signed [fcd_pkg::PHASE_W-1:0]     phase_out
);

   logic signed [fcd_pkg::FORCE_W-1:0] filt_ff, filt_in;
   logic                               landed_ff, landed_in;
   logic [fcd_pkg::TIMER_W-1:0]        timer_ff, timer_in;

   logic signed [fcd_pkg::FORCE_W:0]   diff;
   logic signed [fcd_pkg::FORCE_W:0]   filt_sum;
   logic signed [fcd_pkg::FORCE_W-1:0] filt_new;
   logic                               landed_new;
   logic                               planned;
   logic [fcd_pkg::TIMER_W-1:0]        timer_cur;
   logic [fcd_pkg::TIMER_W:0]          timer_sum;
   logic                               timer_open;
   logic                               delayed;

   // filtered += floor((force - filtered) / 2)
   assign diff = {force_val[fcd_pkg::FORCE_W-1], force_val} - {filt_ff[fcd_pkg::FORCE_W-1], filt_ff};
   assign filt_sum = {filt_ff[fcd_pkg::FORCE_W-1], filt_ff} + (diff >>> 1);
   assign filt_new = filt_sum[fcd_pkg::FORCE_W-1:0];

   always_comb begin
      priority if (filt_new > touchdown_level) begin
         landed_new = 1'b1;
      end else if (filt_new < release_level) begin
         landed_new = 1'b0;
      end else begin
         landed_new = landed_ff;
      end
   end

   // zero or negative phase means planned stance
   assign planned = phase[fcd_pkg::PHASE_W-1] || (phase == '0);
   assign confirm = planned && landed_new;
   // gait change clears the timer before the decision
   assign timer_cur = gait_change ? '0 : timer_ff;
   assign timer_open = ({1'b0, timer_cur} < hold_limit);
   assign timer_sum = {1'b0, timer_cur} + {{(fcd_pkg::TIMER_W + 1 - fcd_pkg::TICK_W){1'b0}}, tick};
   assign delayed = running && !planned && landed_new && hold_enable && timer_open;

   always_comb begin
      status.stance = planned || delayed;
      status.delayed = delayed;
      if (running && (planned || delayed)) begin
         phase_out = '0;
      end else begin
         phase_out = phase;
      end
   end

   always_comb begin
      filt_in = filt_ff;
      landed_in = landed_ff;
      timer_in = timer_ff;
      if (en) begin
         if (running) begin
            filt_in = filt_new;
            landed_in = landed_new;
            if (delayed) begin
               // saturate at full scale
               timer_in = timer_sum[fcd_pkg::TIMER_W] ? '1 : timer_sum[fcd_pkg::TIMER_W-1:0];
            end else begin
               timer_in = '0;
            end
         end else begin
            filt_in = '0;
            landed_in = 1'b0;
            timer_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
         landed_ff <= 1'b0;
         timer_ff <= '0;
      end else begin
         filt_ff <= filt_in;
         landed_ff <= landed_in;
         timer_ff <= timer_in;
      end
   end

endmodule

// ----- hdl/fcd_merge.sv -----
// Merge stage: combines the four lanes into the delay request and forced stance.
// Depends on fcd_pkg for the lane status struct.
module fcd_merge (
   input  logic                                      running,
   input  logic [fcd_pkg::LEGS-1:0]                  confirm,
   input  fcd_pkg::lane_status_type [fcd_pkg::LEGS-1:0] status,
   output logic                                      hold_enable,
   output logic                                      force_leg0,
   output logic [fcd_pkg::LEGS-1:0]                  stance_mask,
   output logic [fcd_pkg::LEGS-1:0]                  delayed_mask
);

   logic [fcd_pkg::LEGS-1:0] stance;
   logic [fcd_pkg::LEGS-1:0] delayed;

   always_comb begin
      for (int i = 0; i < fcd_pkg::LEGS; i++) begin
         stance[i] = status[i].stance;
         delayed[i] = status[i].delayed;
      end
   end

   // delay lift-off only while no leg is both planned stance and landed
   assign hold_enable = ~|confirm;
   assign force_leg0 = running && ~|stance;

   always_comb begin
      stance_mask = stance;
      delayed_mask = running ? delayed : '0;
      if (force_leg0) begin
         stance_mask[0] = 1'b1;
         delayed_mask[0] = 1'b0;
      end
   end

endmodule

// ----- verif/tb_foot_contact_decision.sv -----
// Self-checking testbench for foot_contact_decision: random-paced req/rsp traffic, csr writes
// between runs, with the stance decision predicted in-line and compared field by field.
// Depends on fcd_pkg and the foot_contact_decision RTL.
module tb_foot_contact_decision;

   localparam logic [fcd_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 6;

   typedef struct packed {
      logic [fcd_pkg::LEGS-1:0][fcd_pkg::FORCE_W-1:0] force_in;
      logic [fcd_pkg::LEGS-1:0][fcd_pkg::PHASE_W-1:0] phase;
      logic [fcd_pkg::TICK_W-1:0]                     tick;
      logic [fcd_pkg::STIME_W-1:0]                    stime;
      logic [fcd_pkg::MODE_W-1:0]                     mode;
      logic [fcd_pkg::GAIT_W-1:0]                     gait;
   } tick_item_type;

   typedef struct packed {
      logic [fcd_pkg::LEGS-1:0]                       stance;
      logic [fcd_pkg::LEGS-1:0]                       delayed;
      logic [fcd_pkg::LEGS-1:0][fcd_pkg::PHASE_W-1:0] phase_out;
   } contact_result_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [fcd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [fcd_pkg::CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   tick_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [fcd_pkg::LEGS-1:0] rsp_stance_mask;
   logic [fcd_pkg::LEGS-1:0] rsp_delayed_mask;
   logic signed [fcd_pkg::PHASE_W-1:0] rsp_phase_out_leg0;
   logic signed [fcd_pkg::PHASE_W-1:0] rsp_phase_out_leg1;
   logic signed [fcd_pkg::PHASE_W-1:0] rsp_phase_out_leg2;
   logic signed [fcd_pkg::PHASE_W-1:0] rsp_phase_out_leg3;

   // pending stimulus and expected decisions
   tick_item_type pending_ticks[$];
   contact_result_type expected_contacts[$];
   int ticks_queued = 0;
   int ticks_accepted = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int settings_count = 1;
   int cycle_count = 0;

   // handshake flags seen at the last rising edge
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int req_wait = 0;
   int req_calm = 0;
   int rsp_wait = 0;
   int rsp_calm = 0;

   // predictor copy of the registers and leg state
   logic signed [fcd_pkg::FORCE_W-1:0] td_level = fcd_pkg::TOUCHDOWN_RST;
   logic signed [fcd_pkg::FORCE_W-1:0] rel_level = fcd_pkg::RELEASE_RST;
   logic [fcd_pkg::RATIO_W-1:0] hold_ratio_q = fcd_pkg::HOLD_RATIO_RST;
   int filt_q [fcd_pkg::LEGS] = '{default: 0};
   bit landed_q [fcd_pkg::LEGS] = '{default: 1'b0};
   logic [fcd_pkg::TIMER_W-1:0] hold_timer [fcd_pkg::LEGS] = '{default: '0};
   logic [fcd_pkg::GAIT_W-1:0] gait_q = '0;

   contact_result_type want;
   contact_result_type got;

   foot_contact_decision dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_force_leg0       (req_item.force_in[0]),
      .req_force_leg1       (req_item.force_in[1]),
      .req_force_leg2       (req_item.force_in[2]),
      .req_force_leg3       (req_item.force_in[3]),
      .req_swing_phase_leg0 (req_item.phase[0]),
      .req_swing_phase_leg1 (req_item.phase[1]),
      .req_swing_phase_leg2 (req_item.phase[2]),
      .req_swing_phase_leg3 (req_item.phase[3]),
      .req_tick_time        (req_item.tick),
      .req_stance_time      (req_item.stime),
      .req_gait_mode        (req_item.mode),
      .req_gait_type        (req_item.gait),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_stance_mask      (rsp_stance_mask),
      .rsp_delayed_mask     (rsp_delayed_mask),
      .rsp_phase_out_leg0   (rsp_phase_out_leg0),
      .rsp_phase_out_leg1   (rsp_phase_out_leg1),
      .rsp_phase_out_leg2   (rsp_phase_out_leg2),
      .rsp_phase_out_leg3   (rsp_phase_out_leg3)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Stance decision for one tick; updates the filter, trigger and timer state.
   function automatic contact_result_type predict_contact(input tick_item_type it);
      contact_result_type r;
      int f;
      int d;
      int confirmed;
      bit planned [fcd_pkg::LEGS];
      longint unsigned hold_limit;
      longint unsigned sum;
      r = '0;
      confirmed = 0;
      for (int i = 0; i < fcd_pkg::LEGS; i++)
         planned[i] = (int'($signed(it.phase[i])) <= 0);
      if (it.mode != fcd_pkg::MODE_RUN) begin
         for (int i = 0; i < fcd_pkg::LEGS; i++) begin
            r.phase_out[i] = it.phase[i];
            r.stance[i] = planned[i];
            filt_q[i] = 0;
            landed_q[i] = 1'b0;
            hold_timer[i] = '0;
         end
         return r;
      end
      hold_limit = (64'(hold_ratio_q) * 64'(it.stime)) >> 8;
      if (it.gait != gait_q) begin
         gait_q = it.gait;
         for (int i = 0; i < fcd_pkg::LEGS; i++)
            hold_timer[i] = '0;
      end
      for (int i = 0; i < fcd_pkg::LEGS; i++) begin
         f = int'($signed(it.force_in[i]));
         d = f - filt_q[i];
         // arithmetic shift gives the floor of half the error
         filt_q[i] = filt_q[i] + (d >>> 1);
         if (filt_q[i] > int'(td_level))
            landed_q[i] = 1'b1;
         else if (filt_q[i] < int'(rel_level))
            landed_q[i] = 1'b0;
         if (planned[i] && landed_q[i])
            confirmed++;
      end
      for (int i = 0; i < fcd_pkg::LEGS; i++) begin
         if (planned[i]) begin
            r.stance[i] = 1'b1;
            r.phase_out[i] = '0;
            hold_timer[i] = '0;
         end else if (landed_q[i] && confirmed == 0 && 64'(hold_timer[i]) < hold_limit) begin
            sum = 64'(hold_timer[i]) + 64'(it.tick);
            hold_timer[i] = (sum > 64'hFF_FFFF) ? 24'hFF_FFFF : sum[fcd_pkg::TIMER_W-1:0];
            r.stance[i] = 1'b1;
            r.delayed[i] = 1'b1;
            r.phase_out[i] = '0;
         end else begin
            hold_timer[i] = '0;
            r.phase_out[i] = it.phase[i];
         end
      end
      // no leg left on the ground: pin leg 0
      if (r.stance == '0) begin
         r.stance[0] = 1'b1;
         r.delayed[0] = 1'b0;
         r.phase_out[0] = '0;
      end
      return r;
   endfunction

   function automatic void check_field(input string what, input int want_v, input int got_v);
      if (want_v != got_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s at result %0d: expected %0d, got %0d",
                     what, results_checked, want_v, got_v);
      end
   endfunction

   // Idle or stall length for one item, with occasional stretches of none.
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fcd_pkg::CSR_TOUCHDOWN:  td_level = csr_data;
               fcd_pkg::CSR_RELEASE:    rel_level = csr_data;
               fcd_pkg::CSR_HOLD_RATIO: hold_ratio_q = csr_data[fcd_pkg::RATIO_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_contacts.push_back(predict_contact(req_item));
            ticks_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_contacts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d arrived with no tick outstanding", results_checked);
            end else begin
               want = expected_contacts.pop_front();
               got.stance = rsp_stance_mask;
               got.delayed = rsp_delayed_mask;
               got.phase_out = {rsp_phase_out_leg3, rsp_phase_out_leg2,
                                rsp_phase_out_leg1, rsp_phase_out_leg0};
               check_field("stance_mask", int'(want.stance), int'(got.stance));
               check_field("delayed_mask", int'(want.delayed), int'(got.delayed));
               for (int i = 0; i < fcd_pkg::LEGS; i++)
                  check_field($sformatf("phase_out_leg%0d", i),
                              int'($signed(want.phase_out[i])),
                              int'($signed(got.phase_out[i])));
            end
            results_checked++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until accepted
      end else if (req_wait > 0) begin
         req_valid <= 1'b0;
         req_wait--;
      end else if (pending_ticks.size() != 0) begin
         req_item <= pending_ticks.pop_front();
         req_valid <= 1'b1;
         req_wait = draw_wait(req_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_taken) begin
         rsp_wait = draw_wait(rsp_calm);
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end else if (rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic queue_tick(input tick_item_type it);
      pending_ticks.push_back(it);
      ticks_queued++;
   endtask

   function automatic tick_item_type make_tick(
         input logic [fcd_pkg::MODE_W-1:0] mode,
         input logic [fcd_pkg::GAIT_W-1:0] gait,
         input logic [fcd_pkg::LEGS-1:0][fcd_pkg::FORCE_W-1:0] frc,
         input logic [fcd_pkg::LEGS-1:0][fcd_pkg::PHASE_W-1:0] ph,
         input logic [fcd_pkg::TICK_W-1:0] tick,
         input logic [fcd_pkg::STIME_W-1:0] stime);
      tick_item_type it;
      it.mode = mode;
      it.gait = gait;
      it.force_in = frc;
      it.phase = ph;
      it.tick = tick;
      it.stime = stime;
      return it;
   endfunction

   function automatic logic [fcd_pkg::FORCE_W-1:0] pick_force(input bit loaded);
      int v;
      case ($urandom_range(0, 15))
         0: v = $urandom_range(0, 16'hFFFF);
         1: v = 32767;
         2: v = -32768;
         default: v = loaded ? int'($urandom_range(450, 2600))
                             : int'($urandom_range(0, 560)) - 160;
      endcase
      return v[fcd_pkg::FORCE_W-1:0];
   endfunction

   function automatic logic [fcd_pkg::PHASE_W-1:0] pick_phase(input bit swing);
      int v;
      if (swing)
         v = ($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(1, 32767));
      else
         case ($urandom_range(0, 5))
            0: v = 0;
            1: v = -32768;
            default: v = -int'($urandom_range(1, 32767));
         endcase
      return v[fcd_pkg::PHASE_W-1:0];
   endfunction

   function automatic tick_item_type noise_tick();
      tick_item_type it;
      it.force_in = {$urandom, $urandom};
      it.phase = {$urandom, $urandom};
      it.tick = fcd_pkg::TICK_W'($urandom);
      it.stime = fcd_pkg::STIME_W'($urandom);
      it.mode = fcd_pkg::MODE_W'($urandom_range(0, 3));
      it.gait = fcd_pkg::GAIT_W'($urandom);
      return it;
   endfunction

   // Gait-like sequences: swing legs flip periodically, foot loads follow with a lag,
   // so lift-off delays and forced stance come up naturally.
   task automatic queue_walk(input int n);
      tick_item_type it;
      logic [fcd_pkg::LEGS-1:0] swing;
      logic [fcd_pkg::LEGS-1:0] old_swing;
      logic [fcd_pkg::LEGS-1:0] loaded;
      logic [fcd_pkg::GAIT_W-1:0] gait;
      int period;
      int lag;
      int since;
      int r;
      gait = fcd_pkg::GAIT_W'($urandom);
      swing = fcd_pkg::LEGS'($urandom);
      old_swing = swing;
      period = $urandom_range(2, 12);
      lag = $urandom_range(0, 4);
      since = 0;
      for (int k = 0; k < n; k++) begin
         if (since >= period) begin
            old_swing = swing;
            swing = ($urandom_range(0, 3) == 0) ? fcd_pkg::LEGS'($urandom) : ~swing;
            period = $urandom_range(2, 12);
            since = 0;
         end
         loaded = (since < lag) ? ~old_swing : ~swing;
         if ($urandom_range(0, 19) == 0)
            gait = fcd_pkg::GAIT_W'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            queue_tick(noise_tick());
         end else begin
            it.mode = ($urandom_range(0, 11) == 0) ? fcd_pkg::MODE_W'($urandom_range(0, 3))
                                                    : fcd_pkg::MODE_RUN;
            it.gait = gait;
            for (int i = 0; i < fcd_pkg::LEGS; i++) begin
               it.force_in[i] = pick_force(loaded[i]);
               it.phase[i] = pick_phase(swing[i]);
            end
            r = $urandom_range(0, 15);
            it.tick = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF
                      : (r == 2) ? fcd_pkg::TICK_W'($urandom)
                      : fcd_pkg::TICK_W'($urandom_range(200, 4000));
            r = $urandom_range(0, 15);
            it.stime = (r == 0) ? 24'd0 : (r == 1) ? 24'hFF_FFFF
                       : (r == 2) ? fcd_pkg::STIME_W'($urandom)
                       : fcd_pkg::STIME_W'($urandom_range(1000, 30000));
            queue_tick(it);
         end
         since++;
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (ticks_accepted != ticks_queued || expected_contacts.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [fcd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fcd_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] td, input logic [15:0] rel,
                             input logic [fcd_pkg::RATIO_W-1:0] ratio);
      write_csr(fcd_pkg::CSR_TOUCHDOWN, td);
      write_csr(fcd_pkg::CSR_RELEASE, rel);
      write_csr(fcd_pkg::CSR_HOLD_RATIO,
                {{(fcd_pkg::CSR_DATA_W-fcd_pkg::RATIO_W){1'b0}}, ratio});
      settings_count++;
   endtask

   initial begin
      int td;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed ticks at the reset register values
      queue_tick(make_tick(fcd_pkg::MODE_STAND, 3'd0,
                           {16'h7FFF, 16'h8000, 16'h0000, 16'h0001},
                           {16'h8000, 16'h0000, 16'h0001, 16'h7FFF}, 16'd0, 24'd0));
      queue_tick(make_tick(fcd_pkg::MODE_STOP, 3'd7,
                           {16'h8000, 16'h7FFF, 16'h0001, 16'h0000},
                           {16'h7FFF, 16'h0001, 16'h0000, 16'h8000}, 16'hFFFF, 24'hFF_FFFF));
      queue_tick(make_tick(MODE_SPARE, 3'd5, {4{16'h7FFF}},
                           {16'h0000, 16'h7FFF, 16'h8000, 16'h0001}, 16'd100, 24'd500));
      // all legs planned swing but loaded: lift-off delayed, timers step by the tick
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd0, {4{16'h7FFF}}, {4{16'h7FFF}},
                           16'd1000, 24'd10000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd0, {4{16'h7FFF}}, {4{16'h7FFF}},
                           16'd1000, 24'd10000));
      // gait change clears the timers
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h7FFF}}, {4{16'h7FFF}},
                           16'd1000, 24'd10000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h7FFF}}, {4{16'h7FFF}},
                           16'd1000, 24'd10000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h7FFF}}, {4{16'h7FFF}},
                           16'd1000, 24'd10000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h7FFF}}, {4{16'h7FFF}},
                           16'd1000, 24'd10000));
      // timer reaches the limit: released, nothing left in stance
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h7FFF}}, {4{16'h7FFF}},
                           16'd1000, 24'd10000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h8000}}, {4{16'h7FFF}},
                           16'd1000, 24'd10000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h0300}},
                           {16'h0001, 16'h7FFF, 16'h8000, 16'h0000}, 16'd1000, 24'd10000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h7FFF}}, {4{16'h4000}},
                           16'd0, 24'd10000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h7FFF}}, {4{16'h4000}},
                           16'd500, 24'd0));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd2, {4{16'h7FFF}},
                           {16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF}, 16'd500, 24'd9000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd7, {4{16'h7FFF}}, {4{16'h0001}},
                           16'hFFFF, 24'hFF_FFFF));
      // load between the two levels: trigger holds its state
      for (int k = 0; k < 4; k++)
         queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd7, {4{16'h0200}}, {4{16'h2000}},
                              16'd300, 24'd4000));
      queue_tick(make_tick(fcd_pkg::MODE_STAND, 3'd1, {4{16'h0200}}, {4{16'h2000}},
                           16'd300, 24'd4000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd7, {4{16'h0200}}, {4{16'h2000}},
                           16'd300, 24'd4000));
      queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd7, {4{16'h0280}}, {4{16'h2000}},
                           16'd300, 24'd4000));
      queue_walk(100);
      drain();

      // full ratio: a long delay pushes the timer into saturation
      set_config(16'd640, 16'd320, 9'd256);
      for (int k = 0; k < 280; k++)
         queue_tick(make_tick(fcd_pkg::MODE_RUN, 3'd3, {4{16'h7FFF}}, {4{16'h4000}},
                              16'hFFFF, 24'hFF_FFFF));
      queue_walk(85);
      drain();

      set_config(16'd0, 16'd0, 9'd0);
      queue_walk(85);
      drain();

      set_config(16'h7FFF, 16'h8000, 9'd1);
      queue_walk(85);
      drain();

      // release level above touchdown level
      set_config(16'h8000, 16'h7FFF, 9'd255);
      queue_walk(85);
      drain();

      for (int p = 0; p < 3; p++) begin
         td = $urandom_range(200, 1500);
         set_config(td[15:0], 16'($urandom_range(0, td + 200)),
                    fcd_pkg::RATIO_W'($urandom_range(0, 256)));
         queue_walk(85);
         drain();
      end

      set_config(16'd640, 16'd320, 9'd128);
      queue_walk(85);
      drain();

      $display("covered %0d ticks over %0d register settings, %0d decisions checked",
               ticks_accepted, settings_count, results_checked);
      $display("%0d mismatches, %0d decisions still outstanding",
               mismatch_count, expected_contacts.size());
      if (mismatch_count == 0 && expected_contacts.size() == 0)
         $display("[foot_contact_decision] OK");
      else
         $display("[foot_contact_decision] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("[foot_contact_decision] ERROR");
      $finish;
   end

endmodule
